// File: hdl/csdm_pkg.sv
package csdm_pkg;

  // Default fraction widths of the sample and disk coordinates
  localparam int IN_FRAC_BITS_DEF  = 16;
  localparam int OUT_FRAC_BITS_DEF = 15;

  // Angle and trig values are Q30 magnitudes in 31 bits
  localparam int Q30_FRAC = 30;
  localparam int Q30_W    = 31;

  localparam logic [Q30_W-1:0] Q30_ONE = 31'd1073741824;

  // sin(q*pi/4): terms in q, q^3, q^5, q^7
  localparam logic [Q30_W-1:0] SIN_C0 = 31'd843314857;
  localparam logic [Q30_W-1:0] SIN_C1 = 31'd86699834;
  localparam logic [Q30_W-1:0] SIN_C2 = 31'd2674041;
  localparam logic [Q30_W-1:0] SIN_C3 = 31'd39273;

  // cos(q*pi/4): terms in q^2, q^4, q^6, q^8
  localparam logic [Q30_W-1:0] COS_C0 = 31'd331168967;
  localparam logic [Q30_W-1:0] COS_C1 = 31'd17023472;
  localparam logic [Q30_W-1:0] COS_C2 = 31'd350031;
  localparam logic [Q30_W-1:0] COS_C3 = 31'd3856;

  // Round a Q30 x Q30 product magnitude to nearest, ties away from zero
  function automatic logic [Q30_W-1:0] rnd_q30(input logic [2*Q30_W-1:0] p);
    logic [2*Q30_W:0] s;
    s = {1'b0, p} + ({{(2*Q30_W){1'b0}}, 1'b1} << (Q30_FRAC - 1));
    return s[Q30_FRAC+Q30_W-1:Q30_FRAC];
  endfunction

endpackage

// File: hdl/csdm_in_if.sv
interface csdm_in_if #(
  parameter int W = csdm_pkg::IN_FRAC_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] u_coord;
  logic [W-1:0] v_coord;

  modport source(output valid, output u_coord, output v_coord, input ready);
  modport sink(input valid, input u_coord, input v_coord, output ready);
endinterface

// File: hdl/csdm_out_if.sv
interface csdm_out_if #(
  parameter int W = csdm_pkg::OUT_FRAC_BITS_DEF + 1
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] disk_x;
  logic signed [W-1:0] disk_y;

  modport source(output valid, output disk_x, output disk_y, input ready);
  modport sink(input valid, input disk_x, input disk_y, output ready);
endinterface

// File: hdl/concentric_square_to_disk_map_top.sv
// Concentric square-to-disk map.
//
// in_ch carries one request: a sample (u_coord, v_coord) of the unit square,
// each an unsigned fraction of IN_FRAC_BITS bits. out_ch returns the matching
// point (disk_x, disk_y) of the unit disk, signed Q1.OUT_FRAC_BITS, rounded
// and saturated, one result per request and in request order.
//
// The pipeline has 39 register stages: one stage picks the sector, 31 stages
// form the Q30 quotient one bit each (restoring divider), five stages run the
// sin/cos polynomials with one multiplier level each, one stage scales by the
// radius and the last rounds and saturates into the output register.
// Throughput is one request per cycle while out_ch.ready stays high.
//
// Every stage carries a valid bit and advances when it is empty or the stage
// after it advances, so bubbles collapse while out_ch.ready is low and in_ch
// keeps accepting until every stage is full. Nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline; data registers are not reset.
module concentric_square_to_disk_map_top #(
  parameter int IN_FRAC_BITS  = csdm_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = csdm_pkg::OUT_FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  csdm_in_if.sink  in_ch,
  csdm_out_if.source out_ch
);
  import csdm_pkg::*;

  localparam int N    = IN_FRAC_BITS;
  localparam int M    = OUT_FRAC_BITS;
  localparam int NB   = N + 1;          // radius / quotient operand magnitude
  localparam int NDIV = Q30_W;          // one quotient bit per stage
  localparam int DIV_END = NDIV;        // stage holding the full quotient
  localparam int P1 = DIV_END + 1;
  localparam int P2 = P1 + 1;
  localparam int P3 = P2 + 1;
  localparam int P4 = P3 + 1;
  localparam int P5 = P4 + 1;
  localparam int P6 = P5 + 1;
  localparam int P7 = P6 + 1;
  localparam int NST = P7 + 1;
  localparam int SH = N + Q30_FRAC - M;
  localparam int PW = NB + Q30_W;
  localparam int MW = PW - SH + 1;

  // Stage handshake: a stage loads when it is empty or its successor loads
  logic [NST-1:0] vld;
  logic [NST-1:0] adv;

  assign adv[NST-1] = !vld[NST-1] || out_ch.ready;
  genvar g;
  generate
    for (g = 0; g < NST - 1; g++) begin : g_adv
      assign adv[g] = !vld[g] || adv[g+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_ch.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ch.ready = adv[0];

  // Sector select: map to [-1,1), compare a against b and -b
  logic signed [N+1:0] a_val;
  logic signed [N+1:0] b_val;
  logic signed [N+2:0] ab_sum;
  logic                upper;
  logic                a_gt_b;
  logic                a_lt_b;
  logic signed [N+1:0] num_sel;
  logic signed [N+1:0] den_sel;
  logic [N+1:0]        num_abs;
  logic [N+1:0]        den_abs;
  logic                swap_in;
  logic                neg_in;

  assign a_val  = $signed({1'b0, in_ch.u_coord, 1'b0}) - $signed({2'b01, {N{1'b0}}});
  assign b_val  = $signed({1'b0, in_ch.v_coord, 1'b0}) - $signed({2'b01, {N{1'b0}}});
  assign ab_sum = (N+3)'(a_val) + (N+3)'(b_val);
  assign upper  = ab_sum > 0;
  assign a_gt_b = a_val > b_val;
  assign a_lt_b = a_val < b_val;

  // Sectors with a dominant take q = b/a, the others q = a/b; r = |den|
  always_comb begin
    if (upper) begin
      swap_in = !a_gt_b;
      neg_in  = 1'b0;
    end else begin
      swap_in = !a_lt_b;
      neg_in  = 1'b1;
    end
    num_sel = swap_in ? a_val : b_val;
    den_sel = swap_in ? b_val : a_val;
    num_abs = num_sel[N+1] ? (~num_sel + 1'b1) : num_sel;
    den_abs = den_sel[N+1] ? (~den_sel + 1'b1) : den_sel;
  end

  // Sideband carried down every stage up to the scaling stage
  logic [NB-1:0] r_s    [0:P5];
  logic          swap_s [0:P5];
  logic          neg_s  [0:P5];
  logic          qneg_s [0:P5];
  logic [NB-1:0] num_s0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      r_s[0]    <= den_abs[N:0];
      num_s0    <= num_abs[N:0];
      swap_s[0] <= swap_in;
      neg_s[0]  <= neg_in;
      qneg_s[0] <= num_sel[N+1] ^ den_sel[N+1];
    end
  end

  generate
    for (g = 1; g <= P5; g++) begin : g_side
      always_ff @(posedge clk) begin
        if (adv[g]) begin
          r_s[g]    <= r_s[g-1];
          swap_s[g] <= swap_s[g-1];
          neg_s[g]  <= neg_s[g-1];
          qneg_s[g] <= qneg_s[g-1];
        end
      end
    end
  endgenerate

  // Restoring divider: |num| * 2^30 / |den|, integer bit first
  logic [NB-1:0]    rem_d [0:NDIV-1];
  logic [Q30_W-1:0] quo_d [0:NDIV-1];

  generate
    for (g = 0; g < NDIV; g++) begin : g_div
      logic [NB:0]      trial;
      logic [Q30_W-1:0] quo_in;
      logic             qbit;
      logic [NB:0]      diff;

      if (g == 0) begin : g_first
        assign trial  = {1'b0, num_s0};
        assign quo_in = '0;
      end else begin : g_rest
        assign trial  = {rem_d[g-1], 1'b0};
        assign quo_in = quo_d[g-1];
      end

      assign qbit = trial >= {1'b0, r_s[g]};
      assign diff = trial - {1'b0, r_s[g]};

      always_ff @(posedge clk) begin
        if (adv[g+1]) begin
          rem_d[g] <= qbit ? diff[NB-1:0] : trial[NB-1:0];
          quo_d[g] <= {quo_in[Q30_W-2:0], qbit};
        end
      end
    end
  endgenerate

  // Polynomial stages: each has one multiplier level and rounds into registers
  logic [Q30_W-1:0]   q_p1, q_p2, q_p3, q_p4;
  logic [Q30_W-1:0]   q2_p1, q2_p2, q2_p3, q2_p4;
  logic [Q30_W-1:0]   ms_p2, ms_p3, ms_p4;
  logic [Q30_W-1:0]   mc_p2, mc_p3, mc_p4;
  logic [Q30_W-1:0]   sin_p5, cosm_p5;
  logic [2*Q30_W-1:0] pr_q2, pr_s3, pr_c3, pr_s2, pr_c2, pr_s1, pr_c1, pr_s0, pr_c0;
  logic [Q30_W-1:0]   acc_s2, acc_c2, acc_s1, acc_c1, acc_s0, acc_c0;

  assign pr_q2  = quo_d[NDIV-1] * quo_d[NDIV-1];
  assign pr_s3  = q2_p1 * SIN_C3;
  assign pr_c3  = q2_p1 * COS_C3;
  assign acc_s2 = SIN_C2 - ms_p2;
  assign acc_c2 = COS_C2 - mc_p2;
  assign pr_s2  = q2_p2 * acc_s2;
  assign pr_c2  = q2_p2 * acc_c2;
  assign acc_s1 = SIN_C1 - ms_p3;
  assign acc_c1 = COS_C1 - mc_p3;
  assign pr_s1  = q2_p3 * acc_s1;
  assign pr_c1  = q2_p3 * acc_c1;
  assign acc_s0 = SIN_C0 - ms_p4;
  assign acc_c0 = COS_C0 - mc_p4;
  assign pr_s0  = q_p4 * acc_s0;
  assign pr_c0  = q2_p4 * acc_c0;

  always_ff @(posedge clk) begin
    if (adv[P1]) begin
      q_p1  <= quo_d[NDIV-1];
      q2_p1 <= rnd_q30(pr_q2);
    end
    if (adv[P2]) begin
      q_p2  <= q_p1;
      q2_p2 <= q2_p1;
      ms_p2 <= rnd_q30(pr_s3);
      mc_p2 <= rnd_q30(pr_c3);
    end
    if (adv[P3]) begin
      q_p3  <= q_p2;
      q2_p3 <= q2_p2;
      ms_p3 <= rnd_q30(pr_s2);
      mc_p3 <= rnd_q30(pr_c2);
    end
    if (adv[P4]) begin
      q_p4  <= q_p3;
      q2_p4 <= q2_p3;
      ms_p4 <= rnd_q30(pr_s1);
      mc_p4 <= rnd_q30(pr_c1);
    end
    if (adv[P5]) begin
      sin_p5  <= rnd_q30(pr_s0);
      cosm_p5 <= rnd_q30(pr_c0);
    end
  end

  // Radius scaling: route sin/cos to x/y by sector, sign from sector and q
  logic [Q30_W-1:0] cos_p5;
  logic [Q30_W-1:0] tx, ty;
  logic             xneg, yneg;
  logic [PW-1:0]    px_p6, py_p6;
  logic             xneg_p6, yneg_p6;

  assign cos_p5 = Q30_ONE - cosm_p5;
  assign tx     = swap_s[P5] ? sin_p5 : cos_p5;
  assign ty     = swap_s[P5] ? cos_p5 : sin_p5;
  assign xneg   = neg_s[P5] ^ (swap_s[P5] & qneg_s[P5]);
  assign yneg   = neg_s[P5] ^ (!swap_s[P5] & qneg_s[P5]);

  always_ff @(posedge clk) begin
    if (adv[P6]) begin
      px_p6   <= r_s[P5] * tx;
      py_p6   <= r_s[P5] * ty;
      xneg_p6 <= xneg;
      yneg_p6 <= yneg;
    end
  end

  // Round to nearest (ties away), saturate, apply sign
  localparam logic [PW:0]   HALF    = {{PW{1'b0}}, 1'b1} << (SH - 1);
  localparam logic [MW-1:0] POS_MAX = {{(MW-M){1'b0}}, {M{1'b1}}};
  localparam logic [MW-1:0] NEG_MAX = POS_MAX + 1'b1;

  function automatic logic [M:0] finish(input logic [PW-1:0] p, input logic neg);
    logic [PW:0]   s;
    logic [MW-1:0] mag;
    logic [MW-1:0] lim;
    s   = {1'b0, p} + HALF;
    mag = s[PW:SH];
    lim = neg ? NEG_MAX : POS_MAX;
    if (mag > lim) begin
      mag = lim;
    end
    return neg ? (~mag[M:0] + 1'b1) : mag[M:0];
  endfunction

  logic [M:0] dx_q, dy_q;

  always_ff @(posedge clk) begin
    if (adv[P7]) begin
      dx_q <= finish(px_p6, xneg_p6);
      dy_q <= finish(py_p6, yneg_p6);
    end
  end

  assign out_ch.valid  = vld[P7];
  assign out_ch.disk_x = $signed(dx_q);
  assign out_ch.disk_y = $signed(dy_q);

`ifndef SYNTHESIS
  // Input stalls only when every stage holds a request
  a_full_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (&vld))
    else $error("input stalled with an empty stage");

  // Quotient magnitude never exceeds one; the origin has no divisor
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_END] && (r_s[DIV_END] != '0) |-> (quo_d[NDIV-1] <= Q30_ONE))
    else $error("quotient above one");

  // Final remainder of the divider stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_END] && (r_s[DIV_END] != '0) |-> (rem_d[NDIV-1] < r_s[DIV_END]))
    else $error("divider remainder out of range");

  // sin and 1 - cos stay within one away from the origin
  a_trig_bound: assert property (@(posedge clk) disable iff (rst)
    vld[P5] && (r_s[P5] != '0) |-> (sin_p5 <= Q30_ONE) && (cosm_p5 <= Q30_ONE))
    else $error("trig value out of range");
`endif

endmodule
